/* design/bcdc_pkg.sv */
// ----------------------------------------------------------------------------
// bcdc_pkg
// shared types and constants for the binary / packed-bcd add-subtract chain
// ----------------------------------------------------------------------------
package bcdc_pkg;

    // operation codes carried on the mode field
    typedef enum logic [1:0] {
        MODE_BIN_ADD = 2'd0,
        MODE_BIN_SUB = 2'd1,
        MODE_BCD_ADD = 2'd2,
        MODE_BCD_SUB = 2'd3
    } t_mode;

    localparam int BYTE_W = 8;
    // working width of the intermediate sums, wide enough for every case
    localparam int WORK_W = 10;

    localparam logic [WORK_W-1:0] LO_DIGIT_MAX = 10'h009;
    localparam logic [WORK_W-1:0] LO_ADJUST    = 10'h006;
    localparam logic [WORK_W-1:0] HI_MASK      = 10'h1F0;
    localparam logic [WORK_W-1:0] HI_DIGIT_MAX = 10'h090;
    localparam logic [WORK_W-1:0] HI_ADJUST    = 10'h060;
    localparam logic [WORK_W-1:0] HI_BORROW    = 10'h010;

    // result of one byte position
    typedef struct packed {
        logic [BYTE_W-1:0] sum;
        logic              carry;
        logic              ovf;
    } t_alu_res;

endpackage

/* design/bcdc_byte_alu.sv */
// ----------------------------------------------------------------------------
// bcdc_byte_alu
// one byte of binary or packed-bcd add / subtract with carry in and out
// ----------------------------------------------------------------------------
module bcdc_byte_alu
    import bcdc_pkg::*;
(
    input  t_mode             i_mode,
    input  logic [BYTE_W-1:0] i_a,
    input  logic [BYTE_W-1:0] i_b,
    input  logic              i_carry,
    output t_alu_res          o_res
);

    logic [BYTE_W-1:0] bb;
    logic [BYTE_W:0]   bin_sum;
    logic [WORK_W-1:0] add_lo;
    logic [WORK_W-1:0] add_mid;
    logic [WORK_W-1:0] add_r;
    logic [WORK_W-1:0] sub_lo;
    logic [WORK_W-1:0] sub_hi;
    logic [WORK_W-1:0] sub_mid;
    logic [WORK_W-1:0] sub_r;
    logic [WORK_W-1:0] a_lo;
    logic [WORK_W-1:0] b_lo;
    logic [WORK_W-1:0] a_hi;
    logic [WORK_W-1:0] b_hi;

    assign a_lo = {{(WORK_W-4){1'b0}}, i_a[3:0]};
    assign b_lo = {{(WORK_W-4){1'b0}}, i_b[3:0]};
    assign a_hi = {{(WORK_W-BYTE_W){1'b0}}, i_a[7:4], 4'h0};
    assign b_hi = {{(WORK_W-BYTE_W){1'b0}}, i_b[7:4], 4'h0};

    // binary path, subtract adds the inverted operand
    assign bb      = (i_mode == MODE_BIN_SUB) ? ~i_b : i_b;
    assign bin_sum = {1'b0, i_a} + {1'b0, bb} + {{BYTE_W{1'b0}}, i_carry};

    // bcd add with low then high digit correction
    always_comb begin
        add_lo = a_lo + b_lo + {{(WORK_W-1){1'b0}}, i_carry};
        if (add_lo > LO_DIGIT_MAX) begin
            add_lo = add_lo + LO_ADJUST;
        end
        add_mid = add_lo + a_hi + b_hi;
        add_r   = ((add_mid & HI_MASK) > HI_DIGIT_MAX) ? add_mid + HI_ADJUST : add_mid;
    end

    // bcd subtract, values are two's complement modulo the work width
    always_comb begin
        sub_lo = a_lo - b_lo - {{(WORK_W-1){1'b0}}, ~i_carry};
        sub_hi = a_hi - b_hi;
        if (sub_lo[4]) begin
            sub_mid = ((sub_lo - LO_ADJUST) & 10'h00F) | (sub_hi - HI_BORROW);
        end else begin
            sub_mid = (sub_lo & 10'h00F) | sub_hi;
        end
        sub_r = sub_mid[8] ? sub_mid - HI_ADJUST : sub_mid;
    end

    always_comb begin
        case (i_mode)
            MODE_BIN_ADD, MODE_BIN_SUB: begin
                o_res.sum   = bin_sum[BYTE_W-1:0];
                o_res.carry = bin_sum[BYTE_W];
                o_res.ovf   = ~(i_a[7] ^ bb[7]) & (i_a[7] ^ bin_sum[7]);
            end
            MODE_BCD_ADD: begin
                o_res.sum   = add_r[BYTE_W-1:0];
                o_res.carry = |add_r[WORK_W-1:BYTE_W];
                o_res.ovf   = ~(i_a[7] ^ i_b[7]) & (i_a[7] ^ add_r[7]);
            end
            default: begin
                o_res.sum   = sub_r[BYTE_W-1:0];
                o_res.carry = ~(|sub_r[WORK_W-1:BYTE_W]);
                o_res.ovf   = (i_a[7] ^ i_b[7]) & (i_a[7] ^ sub_r[7]);
            end
        endcase
    end

endmodule

/* design/bcd_binary_add_sub_chain_top.sv */
// ----------------------------------------------------------------------------
// bcd_binary_add_sub_chain_top
// multi-byte binary / packed-bcd adder-subtractor, one byte per beat
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready) takes one operand byte pair per beat,
//   least significant byte first; i_first_byte starts a new operation and
//   selects i_carry_in, later beats use the carry kept from the byte before
//   for subtract the carry is active high (1 = no borrow)
//   output channel (o_valid / i_ready) gives one result byte per beat with
//   the carry after it; o_overflow is set only on the beat marked o_is_last
// timing
//   an input beat passes through an input register, then one byte-wide add
//   with nibble correction into the result register
//   throughput is one byte per cycle while i_ready stays high; the kept
//   carry is updated as a byte moves from the input register to the result
//   register, so the next byte sees it in the following cycle
// reset and stall
//   synchronous active-low reset empties both registers and clears the kept
//   carry; a stalled receiver holds the result beat, the input register
//   keeps taking one more byte, then o_ready drops until the result drains
// ----------------------------------------------------------------------------
module bcd_binary_add_sub_chain_top
    import bcdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [BYTE_W-1:0] i_byte_a,
    input  logic [BYTE_W-1:0] i_byte_b,
    input  logic              i_carry_in,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_sum_byte,
    output logic              o_carry_out,
    output logic              o_overflow,
    output logic              o_is_last
);

    // input register
    logic              r_in_valid;
    t_mode             r_mode;
    logic [BYTE_W-1:0] r_a;
    logic [BYTE_W-1:0] r_b;
    logic              r_cin;
    logic              r_first;
    logic              r_last;

    // result register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_sum;
    logic              r_cout;
    logic              r_ovf;
    logic              r_is_last;

    // carry kept between bytes
    logic              r_chain_carry;

    logic              advance;
    logic              take_in;
    logic              carry_sel;
    t_alu_res          alu_res;

    // byte moves forward when the result register is free or being drained
    assign advance   = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready   = ~r_in_valid | advance;
    assign take_in   = i_valid & o_ready;
    assign carry_sel = r_first ? r_cin : r_chain_carry;

    bcdc_byte_alu u_alu (
        .i_mode  (r_mode),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_carry (carry_sel),
        .o_res   (alu_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_chain_carry <= 1'b0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_chain_carry <= alu_res.carry;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_mode  <= t_mode'(i_mode);
            r_a     <= i_byte_a;
            r_b     <= i_byte_b;
            r_cin   <= i_carry_in;
            r_first <= i_first_byte;
            r_last  <= i_last_byte;
        end
        if (advance) begin
            r_sum     <= alu_res.sum;
            r_cout    <= alu_res.carry;
            r_ovf     <= alu_res.ovf & r_last;
            r_is_last <= r_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sum_byte  = r_sum;
    assign o_carry_out = r_cout;
    assign o_overflow  = r_ovf;
    assign o_is_last   = r_is_last;

endmodule
